// ===== design/tbu_pkg.sv =====
// shared constants and types for the transformed box union block
package tbu_pkg;

	// depth of the queue between the geometry pipeline and the accumulator
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

	// per-item flags carried alongside the item box
	typedef struct packed {
		logic seen;
		logic last;
	} tbu_flags_t;

	// queue status as seen by the accumulator
	typedef struct packed {
		logic not_empty;
		logic pop;
	} tbu_q_ctrl_t;

endpackage

// ===== design/tbu_front.sv =====
// geometry pipeline: corners, affine transform, saturation and per-item bounds
module tbu_front import tbu_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] box_x,
	input  logic signed [COORD_WIDTH-1:0] box_y,
	input  logic        [COORD_WIDTH-2:0] box_width,
	input  logic        [COORD_WIDTH-2:0] box_height,
	input  logic signed [COORD_WIDTH-1:0] mat_a,
	input  logic signed [COORD_WIDTH-1:0] mat_b,
	input  logic signed [COORD_WIDTH-1:0] mat_c,
	input  logic signed [COORD_WIDTH-1:0] mat_d,
	input  logic signed [COORD_WIDTH-1:0] mat_tx,
	input  logic signed [COORD_WIDTH-1:0] mat_ty,
	input  logic                          child_valid,
	input  logic                          last_child,
	input  logic                          q_pop,
	output logic                          push,
	output logic signed [COORD_WIDTH-1:0] item_min_x,
	output logic signed [COORD_WIDTH-1:0] item_max_x,
	output logic signed [COORD_WIDTH-1:0] item_min_y,
	output logic signed [COORD_WIDTH-1:0] item_max_y,
	output tbu_flags_t                    item_flags
);

	localparam int W   = COORD_WIDTH;
	localparam int CW  = W + 1;
	localparam int PW  = 2 * W + 1;
	localparam int SW  = 2 * W + 2;
	localparam int RW  = SW - FRAC_BITS;
	localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

	logic                 accept;
	logic [CREDIT_W-1:0]  credit_q;

	logic                 vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	tbu_flags_t           flg_s1, flg_s2, flg_s3, flg_s4, flg_s5;

	logic signed [CW-1:0] cx_s1 [2];
	logic signed [CW-1:0] cy_s1 [2];
	logic signed [W-1:0]  ma_s1, mb_s1, mc_s1, md_s1, tx_s1, ty_s1;

	logic signed [PW-1:0] ax_s2 [2];
	logic signed [PW-1:0] cy2_s2 [2];
	logic signed [PW-1:0] bx_s2 [2];
	logic signed [PW-1:0] dy_s2 [2];
	logic signed [W-1:0]  tx_s2, ty_s2;

	logic signed [SW-1:0] sx_s3 [4];
	logic signed [SW-1:0] sy_s3 [4];
	logic signed [W-1:0]  tx_s3, ty_s3;

	logic signed [W-1:0]  px_s4 [4];
	logic signed [W-1:0]  py_s4 [4];

	logic signed [W-1:0]  mnx_a, mnx_b, mxx_a, mxx_b;
	logic signed [W-1:0]  mny_a, mny_b, mxy_a, mxy_b;
	logic signed [W-1:0]  min_x_s5, max_x_s5, min_y_s5, max_y_s5;

	// floor shift, saturate, add translation, saturate again
	function automatic logic signed [W-1:0] sat_affine(
		input logic signed [SW-1:0] sum,
		input logic signed [W-1:0]  t
	);
		logic signed [RW-1:0] r;
		logic signed [W-1:0]  v;
		logic signed [W:0]    e;
		r = sum[SW-1:FRAC_BITS];
		if ((&r[RW-1:W-1]) || !(|r[RW-1:W-1])) begin
			v = r[W-1:0];
		end else if (r[RW-1]) begin
			v = C_MIN;
		end else begin
			v = C_MAX;
		end
		e = {v[W-1], v} + {t[W-1], t};
		if (e[W] != e[W-1]) begin
			sat_affine = e[W] ? C_MIN : C_MAX;
		end else begin
			sat_affine = e[W-1:0];
		end
	endfunction

	// credits cover every item in flight plus every item held in the queue
	assign in_ready = (credit_q < CREDIT_W'(FIFO_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else if (accept && !q_pop) begin
			credit_q <= credit_q + 1'b1;
		end else if (!accept && q_pop) begin
			credit_q <= credit_q - 1'b1;
		end
	end

	// valid bits of the pipeline stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// stage 1: capture transfer and form box corners one bit wider
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_s1[0]    <= {box_x[W-1], box_x};
			cx_s1[1]    <= {box_x[W-1], box_x} + {2'b00, box_width};
			cy_s1[0]    <= {box_y[W-1], box_y};
			cy_s1[1]    <= {box_y[W-1], box_y} + {2'b00, box_height};
			ma_s1       <= mat_a;
			mb_s1       <= mat_b;
			mc_s1       <= mat_c;
			md_s1       <= mat_d;
			tx_s1       <= mat_tx;
			ty_s1       <= mat_ty;
			flg_s1.seen <= child_valid;
			flg_s1.last <= last_child;
		end
	end

	// stage 2: the eight distinct products
	always_ff @(posedge clk) begin
		for (int i = 0; i < 2; i++) begin
			ax_s2[i]  <= ma_s1 * cx_s1[i];
			bx_s2[i]  <= mb_s1 * cx_s1[i];
			cy2_s2[i] <= mc_s1 * cy_s1[i];
			dy_s2[i]  <= md_s1 * cy_s1[i];
		end
		tx_s2  <= tx_s1;
		ty_s2  <= ty_s1;
		flg_s2 <= flg_s1;
	end

	// stage 3: exact product sums for each corner
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			sx_s3[k] <= {ax_s2[k/2][PW-1], ax_s2[k/2]} + {cy2_s2[k%2][PW-1], cy2_s2[k%2]};
			sy_s3[k] <= {bx_s2[k/2][PW-1], bx_s2[k/2]} + {dy_s2[k%2][PW-1], dy_s2[k%2]};
		end
		tx_s3  <= tx_s2;
		ty_s3  <= ty_s2;
		flg_s3 <= flg_s2;
	end

	// stage 4: mapped corner coordinates
	always_ff @(posedge clk) begin
		for (int k = 0; k < 4; k++) begin
			px_s4[k] <= sat_affine(sx_s3[k], tx_s3);
			py_s4[k] <= sat_affine(sy_s3[k], ty_s3);
		end
		flg_s4 <= flg_s3;
	end

	// per-axis bounds of the four corners, two compare levels
	always_comb begin
		mnx_a = (px_s4[0] < px_s4[1]) ? px_s4[0] : px_s4[1];
		mnx_b = (px_s4[2] < px_s4[3]) ? px_s4[2] : px_s4[3];
		mxx_a = (px_s4[0] > px_s4[1]) ? px_s4[0] : px_s4[1];
		mxx_b = (px_s4[2] > px_s4[3]) ? px_s4[2] : px_s4[3];
		mny_a = (py_s4[0] < py_s4[1]) ? py_s4[0] : py_s4[1];
		mny_b = (py_s4[2] < py_s4[3]) ? py_s4[2] : py_s4[3];
		mxy_a = (py_s4[0] > py_s4[1]) ? py_s4[0] : py_s4[1];
		mxy_b = (py_s4[2] > py_s4[3]) ? py_s4[2] : py_s4[3];
	end

	// stage 5: item box, empty box for a marker so the fold leaves state alone
	always_ff @(posedge clk) begin
		if (flg_s4.seen) begin
			min_x_s5 <= (mnx_a < mnx_b) ? mnx_a : mnx_b;
			max_x_s5 <= (mxx_a > mxx_b) ? mxx_a : mxx_b;
			min_y_s5 <= (mny_a < mny_b) ? mny_a : mny_b;
			max_y_s5 <= (mxy_a > mxy_b) ? mxy_a : mxy_b;
		end else begin
			min_x_s5 <= C_MAX;
			max_x_s5 <= C_MIN;
			min_y_s5 <= C_MAX;
			max_y_s5 <= C_MIN;
		end
		flg_s5 <= flg_s4;
	end

	assign push       = vld_s5;
	assign item_min_x = min_x_s5;
	assign item_max_x = max_x_s5;
	assign item_min_y = min_y_s5;
	assign item_max_y = max_y_s5;
	assign item_flags = flg_s5;

endmodule

// ===== design/tbu_fifo.sv =====
// small register queue between the geometry pipeline and the accumulator
module tbu_fifo import tbu_pkg::*; #(
	parameter int DATA_W = 130
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	input  logic              pop,
	output logic              not_empty,
	output logic [DATA_W-1:0] head_data
);

	logic [DATA_W-1:0]   mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CREDIT_W-1:0] count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign not_empty = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];

endmodule

// ===== design/tbu_back.sv =====
// running union fold, group close and result register
module tbu_back import tbu_pkg::*; #(
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  logic signed [COORD_WIDTH-1:0] head_min_x,
	input  logic signed [COORD_WIDTH-1:0] head_max_x,
	input  logic signed [COORD_WIDTH-1:0] head_min_y,
	input  logic signed [COORD_WIDTH-1:0] head_max_y,
	input  tbu_flags_t                    head_flags,
	output tbu_q_ctrl_t                   q_ctrl,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] group_x,
	output logic signed [COORD_WIDTH-1:0] group_y,
	output logic        [COORD_WIDTH-2:0] group_width,
	output logic        [COORD_WIDTH-2:0] group_height,
	output logic                          group_empty
);

	localparam int W = COORD_WIDTH;
	localparam logic signed [W-1:0] C_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] C_MIN = {1'b1, {(W-1){1'b0}}};

	logic signed [W-1:0] run_min_x_q, run_max_x_q, run_min_y_q, run_max_y_q;
	logic                seen_q;
	logic signed [W-1:0] fold_min_x, fold_max_x, fold_min_y, fold_max_y;
	logic signed [W-1:0] snap_min_x_q, snap_max_x_q, snap_min_y_q, snap_max_y_q;
	logic                snap_seen_q, snap_vld_q;
	logic                load_out, snap_free, pop;
	logic        [W-1:0] ext_w, ext_h;

	// queue head folded into the running box
	always_comb begin
		fold_min_x = (head_min_x < run_min_x_q) ? head_min_x : run_min_x_q;
		fold_max_x = (head_max_x > run_max_x_q) ? head_max_x : run_max_x_q;
		fold_min_y = (head_min_y < run_min_y_q) ? head_min_y : run_min_y_q;
		fold_max_y = (head_max_y > run_max_y_q) ? head_max_y : run_max_y_q;
	end

	// a closing item waits for room in the snapshot stage
	assign load_out  = snap_vld_q && (!out_valid || out_ready);
	assign snap_free = !snap_vld_q || load_out;
	assign pop       = head_valid && (!head_flags.last || snap_free);

	assign q_ctrl.not_empty = head_valid;
	assign q_ctrl.pop       = pop;

	// running union state, back to its empty form on a group close
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_x_q <= C_MAX;
			run_max_x_q <= C_MIN;
			run_min_y_q <= C_MAX;
			run_max_y_q <= C_MIN;
			seen_q      <= 1'b0;
		end else if (pop) begin
			if (head_flags.last) begin
				run_min_x_q <= C_MAX;
				run_max_x_q <= C_MIN;
				run_min_y_q <= C_MAX;
				run_max_y_q <= C_MIN;
				seen_q      <= 1'b0;
			end else begin
				run_min_x_q <= fold_min_x;
				run_max_x_q <= fold_max_x;
				run_min_y_q <= fold_min_y;
				run_max_y_q <= fold_max_y;
				seen_q      <= seen_q || head_flags.seen;
			end
		end
	end

	// snapshot of a closed group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_vld_q <= 1'b0;
		end else if (pop && head_flags.last) begin
			snap_vld_q <= 1'b1;
		end else if (load_out) begin
			snap_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_flags.last) begin
			snap_min_x_q <= fold_min_x;
			snap_max_x_q <= fold_max_x;
			snap_min_y_q <= fold_min_y;
			snap_max_y_q <= fold_max_y;
			snap_seen_q  <= seen_q || head_flags.seen;
		end
	end

	// extents are never negative for a group that saw a box
	assign ext_w = snap_max_x_q - snap_min_x_q;
	assign ext_h = snap_max_y_q - snap_min_y_q;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load_out) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (snap_seen_q) begin
				group_x      <= snap_min_x_q;
				group_y      <= snap_min_y_q;
				group_width  <= ext_w[W-1] ? {(W-1){1'b1}} : ext_w[W-2:0];
				group_height <= ext_h[W-1] ? {(W-1){1'b1}} : ext_h[W-2:0];
				group_empty  <= 1'b0;
			end else begin
				group_x      <= '0;
				group_y      <= '0;
				group_width  <= '0;
				group_height <= '0;
				group_empty  <= 1'b1;
			end
		end
	end

endmodule

// ===== design/transformed_bbox_union.sv =====
// top level: union of affine-transformed child boxes, one group result per last item
//
// One child item is taken per clock while in_ready is high. Each item passes a
// five-stage geometry pipeline (corners, eight products, sums, saturated
// mapped corners, item bounds), then an eight-entry queue, then the accumulator
// that folds it into the running union. When its closing item leaves the
// queue, a group result is registered in the snapshot stage and then in the
// result register, which raises out_valid. Input ready is a credit count of
// items in the pipeline and queue; with the output taken promptly the block
// sustains one item per cycle. A stalled output fills the queue and then holds
// in_ready low. Arithmetic is signed fixed point with FRAC_BITS fraction bits;
// mapped corners and extents saturate.
module transformed_bbox_union import tbu_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] box_x,
	input  logic signed [COORD_WIDTH-1:0] box_y,
	input  logic        [COORD_WIDTH-2:0] box_width,
	input  logic        [COORD_WIDTH-2:0] box_height,
	input  logic signed [COORD_WIDTH-1:0] mat_a,
	input  logic signed [COORD_WIDTH-1:0] mat_b,
	input  logic signed [COORD_WIDTH-1:0] mat_c,
	input  logic signed [COORD_WIDTH-1:0] mat_d,
	input  logic signed [COORD_WIDTH-1:0] mat_tx,
	input  logic signed [COORD_WIDTH-1:0] mat_ty,
	input  logic                          child_valid,
	input  logic                          last_child,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0] group_x,
	output logic signed [COORD_WIDTH-1:0] group_y,
	output logic        [COORD_WIDTH-2:0] group_width,
	output logic        [COORD_WIDTH-2:0] group_height,
	output logic                          group_empty
);

	localparam int W      = COORD_WIDTH;
	localparam int DATA_W = 4 * W + $bits(tbu_flags_t);

	logic                push;
	logic signed [W-1:0] item_min_x, item_max_x, item_min_y, item_max_y;
	tbu_flags_t          item_flags;
	logic [DATA_W-1:0]   push_data, head_data;
	logic                not_empty;
	tbu_q_ctrl_t         q_ctrl;
	logic signed [W-1:0] head_min_x, head_max_x, head_min_y, head_max_y;
	tbu_flags_t          head_flags;

	tbu_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.box_x       (box_x),
		.box_y       (box_y),
		.box_width   (box_width),
		.box_height  (box_height),
		.mat_a       (mat_a),
		.mat_b       (mat_b),
		.mat_c       (mat_c),
		.mat_d       (mat_d),
		.mat_tx      (mat_tx),
		.mat_ty      (mat_ty),
		.child_valid (child_valid),
		.last_child  (last_child),
		.q_pop       (q_ctrl.pop),
		.push        (push),
		.item_min_x  (item_min_x),
		.item_max_x  (item_max_x),
		.item_min_y  (item_min_y),
		.item_max_y  (item_max_y),
		.item_flags  (item_flags)
	);

	// queue entry packing
	assign push_data = {item_min_x, item_max_x, item_min_y, item_max_y, item_flags};
	assign {head_min_x, head_max_x, head_min_y, head_max_y, head_flags} = head_data;

	tbu_fifo #(
		.DATA_W (DATA_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (q_ctrl.pop),
		.not_empty (not_empty),
		.head_data (head_data)
	);

	tbu_back #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (not_empty),
		.head_min_x   (head_min_x),
		.head_max_x   (head_max_x),
		.head_min_y   (head_min_y),
		.head_max_y   (head_max_y),
		.head_flags   (head_flags),
		.q_ctrl       (q_ctrl),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.group_x      (group_x),
		.group_y      (group_y),
		.group_width  (group_width),
		.group_height (group_height),
		.group_empty  (group_empty)
	);

endmodule
